@@ design/toq_pkg.sv @@
// shared types and constants for the time-ordered event queue
package toq_pkg;

    localparam int POS_W    = 6;
    localparam int KIND_W   = 8;
    localparam int EXT_TW   = 32;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } toq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY0 = 3'd1,
        ST_EMPTYN = 3'd2,
        ST_RANGE  = 3'd3,
        ST_FULL   = 3'd4
    } toq_status_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] idx;
    } toq_cmd_t;

endpackage

@@ design/toq_cell.sv @@
// one slot of the sorted shift chain
module toq_cell
    import toq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int TW  = 32,
    parameter int CW  = 7
) (
    input  logic              clk,
    input  toq_cmd_t          cmd,
    input  logic [CW-1:0]     count,
    input  logic [TW-1:0]     ins_time,
    input  logic [KIND_W-1:0] ins_kind,
    input  logic              prev_le,
    input  logic [TW-1:0]     prev_time,
    input  logic [KIND_W-1:0] prev_kind,
    input  logic [TW-1:0]     next_time,
    input  logic [KIND_W-1:0] next_kind,
    output logic              le,
    output logic [TW-1:0]     time_q,
    output logic [KIND_W-1:0] kind_q
);

    logic [TW-1:0]     time_reg;
    logic [TW-1:0]     time_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;
    logic              live;
    logic              after;

    // occupied and not later than the new entry: stays put on insert
    assign live = CW'(IDX) < count;
    assign le   = live && (time_reg <= ins_time);
    assign after = IDX >= int'(cmd.idx);

    always_comb
    begin
        time_next = time_reg;
        kind_next = kind_reg;
        if (cmd.ins && !le)
        begin
            if (prev_le)
            begin
                time_next = ins_time;
                kind_next = ins_kind;
            end
            else
            begin
                time_next = prev_time;
                kind_next = prev_kind;
            end
        end
        else if (cmd.rem && after)
        begin
            time_next = next_time;
            kind_next = next_kind;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        kind_reg <= kind_next;
    end

    assign time_q = time_reg;
    assign kind_q = kind_reg;

endmodule

@@ design/time_ordered_event_queue.sv @@
// top level: control, output register and the chain of sorted cells
// a request is latched on acceptance and executed once the output register
//   is free or being drained; no new request is taken until it has executed
//   (on insert, all cells compare against the key and shift together)
// reset: entry count and handshake flags clear at once; slot contents are not
//   cleared, and no slot at or beyond the count is ever read
module time_ordered_event_queue
    import toq_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [EXT_TW-1:0]   event_time,
    input  logic [KIND_W-1:0]   event_kind,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [EXT_TW-1:0]   out_time,
    output logic [KIND_W-1:0]   out_kind,
    output logic [OCC_W-1:0]    occupancy
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    // position has POS_W bits, so only the first cells are ever addressed
    localparam int RD   = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);
    localparam int RIW  = $clog2(RD);

    // latched request
    logic                busy_reg;
    logic                busy_next;
    toq_op_t             op_reg;
    toq_op_t             op_next;
    logic [TIME_BITS-1:0] t_reg;
    logic [TIME_BITS-1:0] t_next;
    logic [KIND_W-1:0]   k_reg;
    logic [KIND_W-1:0]   k_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;

    // queue count
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    // output register
    logic                ov_reg;
    logic                ov_next;
    toq_status_t         st_reg;
    toq_status_t         st_next;
    logic [EXT_TW-1:0]   ot_reg;
    logic [EXT_TW-1:0]   ot_next;
    logic [KIND_W-1:0]   ok_reg;
    logic [KIND_W-1:0]   ok_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    logic                accept;
    logic                exec;
    logic                full;
    logic [POS_W-1:0]    idx;
    toq_status_t         st_calc;
    toq_cmd_t            cmd;

    // chain wiring
    logic                cell_le   [DEPTH];
    logic [TIME_BITS-1:0] cell_time [DEPTH];
    logic [KIND_W-1:0]   cell_kind [DEPTH];
    logic [TIME_BITS-1:0] rd_time   [RD];
    logic [KIND_W-1:0]   rd_kind   [RD];

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    // execute once the output register is free or being drained
    assign exec     = busy_reg && (!ov_reg || out_ready);
    assign full     = count_reg == CW'(DEPTH);
    assign idx      = (op_reg == OP_POP) ? '0 : pos_reg;

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            st_calc = full ? ST_FULL : ST_OK;
        end
        else if (count_reg == '0)
        begin
            st_calc = (idx == '0) ? ST_EMPTY0 : ST_EMPTYN;
        end
        else if (CMPW'(idx) >= CMPW'(count_reg))
        begin
            st_calc = ST_RANGE;
        end
        else
        begin
            st_calc = ST_OK;
        end
    end

    always_comb
    begin
        cmd.ins = exec && (op_reg == OP_INSERT) && (st_calc == ST_OK);
        cmd.rem = exec && ((op_reg == OP_POP) || (op_reg == OP_REMOVE))
                  && (st_calc == ST_OK);
        cmd.idx = idx;
    end

    // chain of cells: each compares against the key and shifts with its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 p_le;
        logic [TIME_BITS-1:0] p_time;
        logic [KIND_W-1:0]    p_kind;
        logic [TIME_BITS-1:0] n_time;
        logic [KIND_W-1:0]    n_kind;

        if (i == 0)
        begin : g_head
            // head takes the new entry when it is later than the key
            assign p_le   = 1'b1;
            assign p_time = t_reg;
            assign p_kind = k_reg;
        end
        else
        begin : g_body
            assign p_le   = cell_le[i-1];
            assign p_time = cell_time[i-1];
            assign p_kind = cell_kind[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign n_time = cell_time[i];
            assign n_kind = cell_kind[i];
        end
        else
        begin : g_mid
            assign n_time = cell_time[i+1];
            assign n_kind = cell_kind[i+1];
        end

        toq_cell #(
            .IDX (i),
            .TW  (TIME_BITS),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .count     (count_reg),
            .ins_time  (t_reg),
            .ins_kind  (k_reg),
            .prev_le   (p_le),
            .prev_time (p_time),
            .prev_kind (p_kind),
            .next_time (n_time),
            .next_kind (n_kind),
            .le        (cell_le[i]),
            .time_q    (cell_time[i]),
            .kind_q    (cell_kind[i])
        );
    end

    // addressable window for pop, remove and read
    for (genvar r = 0; r < RD; r++)
    begin : g_rd
        assign rd_time[r] = cell_time[r];
        assign rd_kind[r] = cell_kind[r];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        op_next    = op_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        ov_next    = ov_reg && !out_ready;
        st_next    = st_reg;
        ot_next    = ot_reg;
        ok_next    = ok_reg;
        occ_next   = occ_reg;

        if (accept)
        begin
            busy_next = 1'b1;
            op_next   = toq_op_t'(opcode);
            t_next    = TIME_BITS'(event_time);
            k_next    = event_kind;
            pos_next  = position;
        end

        if (exec)
        begin
            busy_next = 1'b0;
            ov_next   = 1'b1;
            st_next   = st_calc;
            ot_next   = '0;
            ok_next   = '0;
            if (cmd.ins)
            begin
                count_next = count_reg + 1'b1;
                ot_next    = EXT_TW'(t_reg);
                ok_next    = k_reg;
            end
            else if (st_calc == ST_OK)
            begin
                ot_next = EXT_TW'(rd_time[idx[RIW-1:0]]);
                ok_next = rd_kind[idx[RIW-1:0]];
                if (cmd.rem)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            occ_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        t_reg   <= t_next;
        k_reg   <= k_next;
        pos_reg <= pos_next;
        st_reg  <= st_next;
        ot_reg  <= ot_next;
        ok_reg  <= ok_next;
        occ_reg <= occ_next;
    end

    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign out_time  = ot_reg;
    assign out_kind  = ok_reg;
    assign occupancy = occ_reg;

endmodule

@@ design/toq_checker.sv @@
// port-level checks for the event queue, bound to the top level
module toq_checker
    import toq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [EXT_TW-1:0]   out_time,
    input logic [KIND_W-1:0]   out_kind,
    input logic [OCC_W-1:0]    occupancy
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_time)
            && $stable(out_kind) && $stable(occupancy))
        else $error("result changed while stalled");

    // refused or failed operations carry no entry
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (out_time == '0) && (out_kind == '0))
        else $error("failed operation returned data");

    // full refusal only at capacity
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> occupancy == OCC_W'(DEPTH))
        else $error("full reported below capacity");

    // empty codes only on an empty queue
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_EMPTY0) || (status == ST_EMPTYN)) |-> occupancy == '0)
        else $error("empty reported with entries queued");

    // count never exceeds capacity
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 127) || (occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy above capacity");

endmodule

bind time_ordered_event_queue toq_checker #(
    .DEPTH (DEPTH)
) u_toq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_time  (out_time),
    .out_kind  (out_kind),
    .occupancy (occupancy)
);

@@ dv/testbench.sv @@
// self-checking testbench for the time-ordered event queue
import toq_pkg::*;

class event_queue_scoreboard;

    typedef struct {
        logic [EXT_TW-1:0] t;
        logic [KIND_W-1:0] k;
    } queued_event_t;

    typedef struct {
        toq_status_t       st;
        logic [EXT_TW-1:0] t;
        logic [KIND_W-1:0] k;
        logic [OCC_W-1:0]  occ;
    } op_outcome_t;

    int unsigned   depth;
    queued_event_t sorted_events[$];
    op_outcome_t   pending_outcomes[$];
    int unsigned   mismatches;

    function new(int unsigned queue_depth);
        depth      = queue_depth;
        mismatches = 0;
    endfunction

    function int unsigned entry_count();
        return sorted_events.size();
    endfunction

    // apply one accepted operation to the shadow queue, keep its outcome
    function void note_transfer(toq_op_t op, logic [EXT_TW-1:0] t, logic [KIND_W-1:0] k,
                                logic [POS_W-1:0] p);
        op_outcome_t   res;
        queued_event_t ev;
        int unsigned   at;
        int unsigned   idx;
        res.st = ST_OK;
        res.t  = '0;
        res.k  = '0;
        if (op == OP_INSERT) begin
            if (sorted_events.size() >= depth) begin
                res.st = ST_FULL;
            end
            else begin
                // after every entry with time <= t, so ties stay in arrival order
                at = 0;
                while (at < sorted_events.size() && sorted_events[at].t <= t)
                    at++;
                ev.t = t;
                ev.k = k;
                sorted_events.insert(at, ev);
                res.t = t;
                res.k = k;
            end
        end
        else begin
            idx = (op == OP_POP) ? 0 : p;
            if (sorted_events.size() == 0) begin
                res.st = (idx == 0) ? ST_EMPTY0 : ST_EMPTYN;
            end
            else if (idx >= sorted_events.size()) begin
                res.st = ST_RANGE;
            end
            else begin
                res.t = sorted_events[idx].t;
                res.k = sorted_events[idx].k;
                if (op != OP_READ)
                    sorted_events.delete(idx);
            end
        end
        res.occ = OCC_W'(sorted_events.size());
        pending_outcomes.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [EXT_TW-1:0] t,
                               logic [KIND_W-1:0] k, logic [OCC_W-1:0] occ);
        op_outcome_t exp;
        if (pending_outcomes.size() == 0) begin
            $error("result transfer with nothing pending: status %0d out_time %h", st, t);
            mismatches++;
            return;
        end
        exp = pending_outcomes.pop_front();
        if (st !== exp.st) begin
            $error("status: expected %0d, actual %0d", exp.st, st);
            mismatches++;
        end
        if (t !== exp.t) begin
            $error("out_time: expected %h, actual %h", exp.t, t);
            mismatches++;
        end
        if (k !== exp.k) begin
            $error("out_kind: expected %h, actual %h", exp.k, k);
            mismatches++;
        end
        if (occ !== exp.occ) begin
            $error("occupancy: expected %0d, actual %0d", exp.occ, occ);
            mismatches++;
        end
    endfunction

endclass

module testbench;

    localparam int          DEPTH        = 64;
    localparam int unsigned RANDOM_ITEMS = 1650;
    // sized to cover the worst case with the longest gaps and stalls
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [1:0]          opcode     = '0;
    logic [EXT_TW-1:0]   event_time = '0;
    logic [KIND_W-1:0]   event_kind = '0;
    logic [POS_W-1:0]    position   = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [EXT_TW-1:0]   out_time;
    logic [KIND_W-1:0]   out_kind;
    logic [OCC_W-1:0]    occupancy;

    event_queue_scoreboard sb = new(DEPTH);

    int unsigned cycles        = 0;
    int unsigned in_burst_left = 0;

    time_ordered_event_queue #(
        .DEPTH     (DEPTH),
        .TIME_BITS (EXT_TW)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .event_time (event_time),
        .event_kind (event_kind),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_time   (out_time),
        .out_kind   (out_kind),
        .occupancy  (occupancy)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // gap after an input transfer, with occasional back-to-back bursts
    function automatic int unsigned in_gap();
        if (in_burst_left > 0)
        begin
            in_burst_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3)
            in_burst_left = $urandom_range(20, 60);
        return pick_gap();
    endfunction

    // timestamps: small ranges for lots of ties, plus extremes and full range
    function automatic logic [EXT_TW-1:0] random_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 15);
        else if (r < 60)
            return $urandom_range(0, 1000);
        else if (r < 70)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return 32'd1;
                2: return 32'hFFFF_FFFE;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        else
            return $urandom;
    endfunction

    // index: mostly a live entry, sometimes past the count, sometimes anything
    function automatic logic [POS_W-1:0] random_pos(int unsigned count);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65 && count > 0)
            return POS_W'($urandom_range(0, count - 1));
        else if (r < 80 && count < 64)
            return POS_W'($urandom_range(count, 63));
        else
            return POS_W'($urandom_range(0, 63));
    endfunction

    // one operation: present it, hold until the transfer, then maybe go idle
    task automatic send_op(input toq_op_t op, input logic [EXT_TW-1:0] t,
                           input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p);
        int unsigned gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        opcode     <= op;
        event_time <= t;
        event_kind <= k;
        position   <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_transfer(op, t, k, p);
        gap = in_gap();
        if (gap > 0)
        begin
            // idle with garbage on the payload lines
            @(negedge clk);
            in_valid   <= 1'b0;
            opcode     <= 2'($urandom_range(0, 3));
            event_time <= $urandom;
            event_kind <= KIND_W'($urandom_range(0, 255));
            position   <= POS_W'($urandom_range(0, 63));
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // result side: ready high for a run, then a stall of random length
    initial
    begin : result_ready_driver
        int unsigned hold;
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 10)
                hold = $urandom_range(40, 120);
            else
                hold = $urandom_range(0, 6);
            repeat (hold)
                @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1)
                    @(negedge clk);
            end
        end
    end

    // every result transfer is checked against the oldest pending outcome
    initial
    begin : result_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(status, out_time, out_kind, occupancy);
        end
    end

    // watchdog on the whole run
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned phase_kind;
        int unsigned phase_len;
        int unsigned r;
        toq_op_t     op;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty queue in all its forms
        send_op(OP_POP,    32'h1234_5678, 8'h5A, 6'd0);
        send_op(OP_REMOVE, 32'h0,         8'h0,  6'd0);
        send_op(OP_REMOVE, 32'h0,         8'h0,  6'd1);
        send_op(OP_READ,   32'hFFFF_FFFF, 8'hFF, 6'd63);
        send_op(OP_READ,   32'h0,         8'h0,  6'd0);
        // extremes of time and kind, then a three-way tie
        send_op(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 6'd63);
        send_op(OP_INSERT, 32'h0,         8'h00, 6'd0);
        send_op(OP_INSERT, 32'd5,         8'h01, 6'd0);
        send_op(OP_INSERT, 32'd5,         8'h02, 6'd0);
        send_op(OP_INSERT, 32'd5,         8'h03, 6'd0);
        // reads walk the order, ties must come out in arrival order
        send_op(OP_READ,   32'h0,         8'h0,  6'd1);
        send_op(OP_READ,   32'h0,         8'h0,  6'd2);
        send_op(OP_READ,   32'h0,         8'h0,  6'd3);
        send_op(OP_READ,   32'h0,         8'h0,  6'd4);
        // out of range on a non-empty queue
        send_op(OP_READ,   32'h0,         8'h0,  6'd5);
        send_op(OP_READ,   32'h0,         8'h0,  6'd63);
        // removal from the middle, then past the new count
        send_op(OP_REMOVE, 32'h0,         8'h0,  6'd2);
        send_op(OP_REMOVE, 32'h0,         8'h0,  6'd4);
        // drain, then pop once more on empty
        send_op(OP_POP,    32'h0,         8'h0,  6'd0);
        send_op(OP_POP,    32'h0,         8'h0,  6'd0);
        send_op(OP_POP,    32'h0,         8'h0,  6'd0);
        send_op(OP_POP,    32'h0,         8'h0,  6'd0);
        send_op(OP_POP,    32'h0,         8'h0,  6'd0);

        // random phases: fill to full and beyond, drain to empty, mixed, read heavy
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_kind = $urandom_range(0, 3);
            phase_len  = $urandom_range(30, 140);
            repeat (phase_len)
            begin
                r = $urandom_range(0, 99);
                case (phase_kind)
                    0: op = (r < 85) ? OP_INSERT : toq_op_t'(2'($urandom_range(1, 3)));
                    1: op = (r < 15) ? OP_INSERT
                          : (r < 55) ? OP_POP
                          : (r < 90) ? OP_REMOVE : OP_READ;
                    2: op = toq_op_t'(2'($urandom_range(0, 3)));
                    default: op = (r < 50) ? OP_READ
                               : (r < 80) ? OP_INSERT
                               : toq_op_t'(2'($urandom_range(1, 2)));
                endcase
                send_op(op, random_time(), KIND_W'($urandom_range(0, 255)),
                        random_pos(sb.entry_count()));
                sent++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // let every outstanding result drain, then a few quiet cycles
        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
